>>> hw/rtl/pcmf_pkg.sv
// ----------------------------------------------------------------------------
// pcmf_pkg: shared definitions for the plane crossing momentum flux unit
// Fixed-point formats, datapath widths and the magnitude product helper.
// ----------------------------------------------------------------------------
package pcmf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ACC_WIDTH = 48;

   // Magnitudes of intermediate results stay at or below 2^62.
   localparam int MAG_W     = 63;
   // A 63-bit magnitude times a 31-bit operand.
   localparam int PROD_W    = MAG_W + 32;
   // Quotient bits produced by the divider, one per step.
   localparam int DIV_STEPS = 62;

   localparam logic [MAG_W-1:0] INNER_LIM = MAG_W'(1) << 62;

   localparam logic [2:0] CSR_AXIS        = 3'd0;
   localparam logic [2:0] CSR_PLANE_POS   = 3'd1;
   localparam logic [2:0] CSR_BOX_LENGTH  = 3'd2;
   localparam logic [2:0] CSR_HALF_LENGTH = 3'd3;
   localparam logic [2:0] CSR_TIME_STEP   = 3'd4;
   localparam logic [2:0] CSR_ACCEL_COEF  = 3'd5;
   localparam logic [2:0] CSR_FLUX_SCALE  = 3'd6;

   typedef logic signed [ACC_WIDTH-1:0] acc_type;
   typedef logic signed [63:0]          wide_type;

   // Fixed-point product magnitude: drop the fraction bits, then saturate.
   function automatic logic [MAG_W-1:0] mulsh_mag(input logic [PROD_W-1:0] prod);
      logic [PROD_W-1:0] r;
      r = prod >> FRAC_BITS;
      if (r > PROD_W'(INNER_LIM)) begin
         return INNER_LIM;
      end
      return r[MAG_W-1:0];
   endfunction

endpackage

>>> hw/rtl/plane_crossing_momentum_flux_unit.sv
// ----------------------------------------------------------------------------
// plane_crossing_momentum_flux_unit
// Accumulates the kinetic momentum flux of atoms crossing a plane.
// ----------------------------------------------------------------------------
// One atom at a time: req_ready is high only in the idle state, so no new atom
// is taken before the last one is through. An atom outside the group skips the
// arithmetic; a group atom that does not cross skips the flux terms. A result
// beat is written only for the last atom, once any earlier beat has been taken.
// The 62-step divider runs once per component; one 32x31 multiplier is shared.
// Reset is synchronous: sums clear; state, valid and CSRs take their defaults.
module plane_crossing_momentum_flux_unit
   import pcmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_in_group,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic signed [31:0]   req_vel_x,
   input  logic signed [31:0]   req_vel_y,
   input  logic signed [31:0]   req_vel_z,
   input  logic signed [31:0]   req_force_x,
   input  logic signed [31:0]   req_force_y,
   input  logic signed [31:0]   req_force_z,
   input  logic [30:0]          req_atom_mass,
   input  logic                 req_last_atom,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output acc_type              rsp_stress_x,
   output acc_type              rsp_stress_y,
   output acc_type              rsp_stress_z,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_FMUL  = 5'd1;
   localparam logic [4:0] ST_DIV   = 5'd2;
   localparam logic [4:0] ST_HMUL0 = 5'd3;
   localparam logic [4:0] ST_HMUL1 = 5'd4;
   localparam logic [4:0] ST_HFIN  = 5'd5;
   localparam logic [4:0] ST_XLOAD = 5'd6;
   localparam logic [4:0] ST_XMUL0 = 5'd7;
   localparam logic [4:0] ST_XMUL1 = 5'd8;
   localparam logic [4:0] ST_PLANE = 5'd9;
   localparam logic [4:0] ST_CROSS = 5'd10;
   localparam logic [4:0] ST_TLOAD = 5'd11;
   localparam logic [4:0] ST_TMUL0 = 5'd12;
   localparam logic [4:0] ST_TMUL1 = 5'd13;
   localparam logic [4:0] ST_TMID  = 5'd14;
   localparam logic [4:0] ST_SMUL0 = 5'd15;
   localparam logic [4:0] ST_SMUL1 = 5'd16;
   localparam logic [4:0] ST_ACC   = 5'd17;
   localparam logic [4:0] ST_DONE  = 5'd18;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   // Configuration registers.
   logic [1:0]          axis_ff;
   logic signed [31:0]  plane_pos_ff;
   logic [30:0]         box_length_ff, half_length_ff, time_step_ff;
   logic [30:0]         accel_coef_ff, flux_scale_ff;

   // Sequencer and datapath registers.
   logic [4:0]          state_ff, state_in;
   logic [1:0]          comp_ff, comp_in;
   logic [1:0]          ax_ff, ax_in;
   logic                last_ff, last_in;
   logic [30:0]         mass_ff, mass_in;
   logic signed [31:0]  frc_ff [3];
   logic signed [31:0]  frc_in [3];
   logic signed [31:0]  vel_ff [3];
   logic signed [31:0]  vel_in [3];
   logic signed [31:0]  vel_ax_ff, vel_ax_in;
   logic signed [31:0]  pos_ax_ff, pos_ax_in;
   wide_type            vcross_ff [3];
   wide_type            vcross_in [3];
   wide_type            vc_ax_ff, vc_ax_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [30:0]         rem_ff, rem_in;
   logic [5:0]          div_cnt_ff, div_cnt_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   wide_type            xold_ff, xold_in;
   logic signed [33:0]  plane_ff, plane_in;
   acc_type             sums_ff [3];
   acc_type             sums_in [3];
   logic                rsp_valid_ff, rsp_valid_in;
   acc_type             rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   // Shared multiplier.
   logic [31:0]         mul_a;
   logic [30:0]         mul_b;
   logic [62:0]         mul_out;

   // Per-state temporaries.
   logic [31:0]         div_trial;
   logic                div_ge;
   logic [DIV_STEPS-1:0] quo_next;
   logic [MAG_W-1:0]    mres;
   wide_type            half_h, vc_new, prod_sgn, t_val;
   logic signed [64:0]  xdiff, acc_sum;
   logic signed [32:0]  side_chk, dn_raw;
   logic signed [33:0]  img;
   logic signed [34:0]  di_raw, sn;
   logic [34:0]         dn_abs, di_abs;
   logic signed [65:0]  so;
   logic [30:0]         mass_raw;

   assign mul_out = 63'(mul_a) * 63'(mul_b);

   always_comb begin
      unique case (state_ff)
         ST_FMUL:                               mul_b = accel_coef_ff;
         ST_HMUL0, ST_HMUL1, ST_XMUL0, ST_XMUL1: mul_b = time_step_ff;
         ST_TMUL0, ST_TMUL1:                    mul_b = mass_ff;
         default:                               mul_b = flux_scale_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      ax_in        = ax_ff;
      last_in      = last_ff;
      mass_in      = mass_ff;
      vel_ax_in    = vel_ax_ff;
      pos_ax_in    = pos_ax_ff;
      vc_ax_in     = vc_ax_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      xold_in      = xold_ff;
      plane_in     = plane_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < 3; i++) begin
         frc_in[i]    = frc_ff[i];
         vel_in[i]    = vel_ff[i];
         vcross_in[i] = vcross_ff[i];
         sums_in[i]   = sums_ff[i];
      end
      mul_a     = mag_ff[31:0];
      div_trial = {rem_ff, quo_ff[DIV_STEPS-1]};
      div_ge    = div_trial >= {1'b0, mass_ff};
      quo_next  = {quo_ff[DIV_STEPS-2:0], div_ge};
      mres      = mulsh_mag(prod_ff);
      half_h    = {2'b00, mres[MAG_W-1:1]};
      vc_new    = frc_ff[comp_ff][31] ? 64'(vel_ff[comp_ff]) + half_h
                                      : 64'(vel_ff[comp_ff]) - half_h;
      prod_sgn  = vc_ax_ff[63] ? -wide_type'({1'b0, mres}) : wide_type'({1'b0, mres});
      xdiff     = 65'(pos_ax_ff) - 65'(prod_sgn);
      side_chk  = 33'($signed({1'b0, half_length_ff})) - 33'(plane_pos_ff);
      img       = side_chk[32] ? 34'(plane_pos_ff) - 34'($signed({1'b0, box_length_ff}))
                               : 34'(plane_pos_ff) + 34'($signed({1'b0, box_length_ff}));
      dn_raw    = 33'(pos_ax_ff) - 33'(plane_pos_ff);
      di_raw    = 35'(pos_ax_ff) - 35'(img);
      dn_abs    = dn_raw[32] ? 35'(-dn_raw) : 35'(dn_raw);
      di_abs    = di_raw[34] ? 35'(-di_raw) : 35'(di_raw);
      sn        = 35'(pos_ax_ff) - 35'(plane_ff);
      so        = 66'(xold_ff) - 66'(plane_ff);
      t_val     = (vcross_ff[comp_ff][63] ^ vel_ax_ff[31]) ? -wide_type'({1'b0, mres})
                                                           : wide_type'({1'b0, mres});
      acc_sum   = 65'(sums_ff[comp_ff]) + 65'(t_val);
      mass_raw  = (req_atom_mass == '0) ? 31'd1 : req_atom_mass;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ax_in      = (axis_ff == 2'd3) ? 2'd2 : axis_ff;
               last_in    = req_last_atom;
               mass_in    = mass_raw;
               frc_in[0]  = req_force_x;
               frc_in[1]  = req_force_y;
               frc_in[2]  = req_force_z;
               vel_in[0]  = req_vel_x;
               vel_in[1]  = req_vel_y;
               vel_in[2]  = req_vel_z;
               case (axis_ff)
                  2'd0: begin
                     vel_ax_in = req_vel_x;
                     pos_ax_in = req_pos_x;
                  end
                  2'd1: begin
                     vel_ax_in = req_vel_y;
                     pos_ax_in = req_pos_y;
                  end
                  default: begin
                     vel_ax_in = req_vel_z;
                     pos_ax_in = req_pos_z;
                  end
               endcase
               comp_in  = 2'd0;
               state_in = req_in_group ? ST_FMUL : ST_DONE;
            end
         end
         ST_FMUL: begin
            mul_a      = frc_ff[comp_ff][31] ? 32'(-33'(frc_ff[comp_ff]))
                                             : 32'(frc_ff[comp_ff]);
            quo_in     = mul_out[DIV_STEPS-1:0];
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division of |force| * accel_coef by the mass.
            rem_in     = div_ge ? 31'(div_trial - {1'b0, mass_ff}) : div_trial[30:0];
            quo_in     = quo_next;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               mag_in   = {1'b0, quo_next};
               state_in = ST_HMUL0;
            end
         end
         ST_HMUL0, ST_XMUL0, ST_TMUL0, ST_SMUL0: begin
            prod_in  = {32'd0, mul_out};
            state_in = state_ff + 5'd1;
         end
         ST_HMUL1, ST_XMUL1, ST_TMUL1, ST_SMUL1: begin
            mul_a    = {1'b0, mag_ff[MAG_W-1:32]};
            prod_in  = prod_ff + {mul_out, 32'd0};
            state_in = state_ff + 5'd1;
         end
         ST_HFIN: begin
            vcross_in[comp_ff] = vc_new;
            if (comp_ff == ax_ff) begin
               vc_ax_in = vc_new;
            end
            if (comp_ff == 2'd2) begin
               comp_in  = 2'd0;
               state_in = ST_XLOAD;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_FMUL;
            end
         end
         ST_XLOAD: begin
            mag_in   = vc_ax_ff[63] ? MAG_W'(-vc_ax_ff) : vc_ax_ff[MAG_W-1:0];
            state_in = ST_XMUL0;
         end
         ST_PLANE: begin
            // Back step of the position, clamped to the inner range.
            if (xdiff > 65'($signed({1'b0, INNER_LIM}))) begin
               xold_in = wide_type'({1'b0, INNER_LIM});
            end else if (xdiff < -65'($signed({1'b0, INNER_LIM}))) begin
               xold_in = -wide_type'({1'b0, INNER_LIM});
            end else begin
               xold_in = xdiff[63:0];
            end
            plane_in = (dn_abs < di_abs) ? 34'(plane_pos_ff) : img;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            comp_in = 2'd0;
            if ((sn > 0 && so < 0) || (sn < 0 && so > 0)) begin
               state_in = ST_TLOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TLOAD: begin
            mag_in   = vcross_ff[comp_ff][63] ? MAG_W'(-vcross_ff[comp_ff])
                                              : vcross_ff[comp_ff][MAG_W-1:0];
            state_in = ST_TMUL0;
         end
         ST_TMID: begin
            mag_in   = mres;
            state_in = ST_SMUL0;
         end
         ST_ACC: begin
            if (acc_sum > 65'(ACC_MAX)) begin
               sums_in[comp_ff] = ACC_MAX;
            end else if (acc_sum < 65'(ACC_MIN)) begin
               sums_in[comp_ff] = ACC_MIN;
            end else begin
               sums_in[comp_ff] = acc_sum[ACC_WIDTH-1:0];
            end
            if (comp_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_TLOAD;
            end
         end
         ST_DONE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_x_in     = sums_ff[0];
               rsp_y_in     = sums_ff[1];
               rsp_z_in     = sums_ff[2];
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  sums_in[i] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         axis_ff        <= 2'd2;
         plane_pos_ff   <= '0;
         box_length_ff  <= 31'(1) << FRAC_BITS;
         half_length_ff <= 31'(1) << (FRAC_BITS - 1);
         time_step_ff   <= 31'(1) << FRAC_BITS;
         accel_coef_ff  <= 31'(1) << FRAC_BITS;
         flux_scale_ff  <= 31'(1) << FRAC_BITS;
         for (int i = 0; i < 3; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            sums_ff[i] <= sums_in[i];
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_AXIS:        axis_ff        <= csr_data[1:0];
               CSR_PLANE_POS:   plane_pos_ff   <= csr_data;
               CSR_BOX_LENGTH:  box_length_ff  <= csr_data[30:0];
               CSR_HALF_LENGTH: half_length_ff <= csr_data[30:0];
               CSR_TIME_STEP:   time_step_ff   <= csr_data[30:0];
               CSR_ACCEL_COEF:  accel_coef_ff  <= csr_data[30:0];
               CSR_FLUX_SCALE:  flux_scale_ff  <= csr_data[30:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      comp_ff    <= comp_in;
      ax_ff      <= ax_in;
      last_ff    <= last_in;
      mass_ff    <= mass_in;
      vel_ax_ff  <= vel_ax_in;
      pos_ax_ff  <= pos_ax_in;
      vc_ax_ff   <= vc_ax_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      mag_ff     <= mag_in;
      prod_ff    <= prod_in;
      xold_ff    <= xold_in;
      plane_ff   <= plane_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      for (int i = 0; i < 3; i++) begin
         frc_ff[i]    <= frc_in[i];
         vel_ff[i]    <= vel_in[i];
         vcross_ff[i] <= vcross_in[i];
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_stress_x = rsp_x_ff;
   assign rsp_stress_y = rsp_y_ff;
   assign rsp_stress_z = rsp_z_ff;

endmodule

>>> hw/rtl/pcmf_checker.sv
// ----------------------------------------------------------------------------
// pcmf_checker
// Port-level checks of the momentum flux unit, bound to its top level.
// ----------------------------------------------------------------------------
module pcmf_checker
   import pcmf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input acc_type rsp_stress_x,
   input acc_type rsp_stress_y,
   input acc_type rsp_stress_z
);

   // A waiting result beat holds its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stress_x)
         && $stable(rsp_stress_y) && $stable(rsp_stress_z))
      else $error("result beat dropped or changed while stalled");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted atom keeps the unit busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("unit ready right after accepting an atom");

   // A new result only appears as the unit finishes an atom.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a finished atom");

endmodule

bind plane_crossing_momentum_flux_unit pcmf_checker u_pcmf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_stress_x (rsp_stress_x),
   .rsp_stress_y (rsp_stress_y),
   .rsp_stress_z (rsp_stress_z)
);
